// ----- hw/rtl/spto_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Segment path 2-opt package
// Shared constants and payload types for the segment path optimizer.
// ----------------------------------------------------------------------------
package spto_pkg;
    localparam int MAX_SEGMENTS = 64;
    localparam int COORD_BITS   = 16;
    localparam int IDX_BITS     = $clog2(MAX_SEGMENTS);
    localparam int CNT_BITS     = IDX_BITS + 1;
    localparam int DIFF_BITS    = COORD_BITS + 1;
    localparam int SQ_BITS      = 2 * DIFF_BITS + 2;
    localparam int ROOT_BITS    = (SQ_BITS + 1) / 2;
    localparam int DIST_BITS    = 23;
    localparam int ACC_BITS     = ROOT_BITS + CNT_BITS + 1;
    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

    localparam logic [1:0] REG_SEGMENT_COUNT = 2'd0;
    localparam logic [1:0] REG_MAX_PASSES    = 2'd1;
    localparam logic [1:0] REG_MARGIN        = 2'd2;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        logic   mode;
        t_coord start_x;
        t_coord start_y;
        t_coord end_x;
        t_coord end_y;
    } t_in_item;

    typedef struct packed {
        logic [5:0]           original_index;
        logic                 flipped;
        logic                 last;
        logic [15:0]          pass_count;
        logic [DIST_BITS-1:0] initial_distance;
        logic [DIST_BITS-1:0] final_distance;
    } t_out_item;

    typedef struct packed {
        t_coord sx;
        t_coord sy;
        t_coord ex;
        t_coord ey;
        logic [IDX_BITS-1:0] ord;
        logic                flip;
    } t_entry;
endpackage
`default_nettype wire

// ----- hw/rtl/spto_dist.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Segment path 2-opt distance unit
// Squares the point difference, then takes a floor square root two bits a cycle.
// ----------------------------------------------------------------------------
module spto_dist (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_go,
    input  wire spto_pkg::t_coord i_x1,
    input  wire spto_pkg::t_coord i_y1,
    input  wire spto_pkg::t_coord i_x2,
    input  wire spto_pkg::t_coord i_y2,
    output logic                  o_done,
    output logic [spto_pkg::ROOT_BITS-1:0] o_dist
);
    import spto_pkg::*;
    localparam int STEP_BITS = $clog2(ROOT_BITS + 2);

    logic [DIFF_BITS-1:0] r_dx, r_dy;
    logic [SQ_BITS-1:0]   r_rem;
    logic [ROOT_BITS-1:0] r_root;
    logic [STEP_BITS-1:0] r_step;
    logic [1:0]           r_phase;
    logic [SQ_BITS-1:0]   r_sqx;
    logic [SQ_BITS-1:0]   n_try;
    logic [SQ_BITS-1:0]   n_rem_sh;
    logic signed [DIFF_BITS-1:0] n_dx, n_dy;

    assign n_dx = DIFF_BITS'(i_x1) - DIFF_BITS'(i_x2);
    assign n_dy = DIFF_BITS'(i_y1) - DIFF_BITS'(i_y2);
    assign n_rem_sh = r_rem;
    assign n_try = SQ_BITS'({r_root, 2'b01});

    always_ff @(posedge i_clk) begin
        o_done <= 1'b0;
        if (!i_rst_n) begin
            r_phase <= 2'd0;
        end else if (i_go) begin
            r_dx    <= n_dx[DIFF_BITS-1] ? DIFF_BITS'(-n_dx) : n_dx;
            r_dy    <= n_dy[DIFF_BITS-1] ? DIFF_BITS'(-n_dy) : n_dy;
            r_phase <= 2'd1;
        end else if (r_phase == 2'd1) begin
            r_sqx   <= SQ_BITS'(r_dx) * SQ_BITS'(r_dx);
            r_rem   <= SQ_BITS'(r_dy) * SQ_BITS'(r_dy);
            r_phase <= 2'd2;
        end else if (r_phase == 2'd2) begin
            r_sqx   <= r_sqx + r_rem;
            r_rem   <= '0;
            r_root  <= '0;
            r_step  <= STEP_BITS'(ROOT_BITS);
            r_phase <= 2'd3;
        end else if (r_phase == 2'd3) begin
            logic [SQ_BITS+1:0] cand;
            logic [SQ_BITS+1:0] tr;
            cand = {n_rem_sh, r_sqx[SQ_BITS-1 -: 2]};
            tr = (SQ_BITS + 2)'(n_try);
            r_sqx <= {r_sqx[SQ_BITS-3:0], 2'b00};
            if (cand >= tr) begin
                r_rem  <= SQ_BITS'(cand - tr);
                r_root <= {r_root[ROOT_BITS-2:0], 1'b1};
            end else begin
                r_rem  <= SQ_BITS'(cand);
                r_root <= {r_root[ROOT_BITS-2:0], 1'b0};
            end
            r_step <= r_step - 1'b1;
            if (r_step == STEP_BITS'(1)) begin
                r_phase <= 2'd0;
                o_done  <= 1'b1;
            end
        end
    end

    assign o_dist = r_root;
endmodule
`default_nettype wire

// ----- hw/rtl/spto_store.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Segment path 2-opt segment store
// Synchronous segment memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module spto_store (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [spto_pkg::IDX_BITS-1:0] i_waddr,
    input  wire spto_pkg::t_entry              i_wdata,
    input  wire logic [spto_pkg::IDX_BITS-1:0] i_raddr,
    output spto_pkg::t_entry                   o_rdata
);
    import spto_pkg::*;
    t_entry r_mem [MAX_SEGMENTS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- hw/rtl/segment_path_two_opt_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Segment path 2-opt unit
// Loads segments into a store and shortens pen-up travel by 2-opt passes.
// ----------------------------------------------------------------------------
// Loads may arrive back to back. A run keeps busy high while each candidate
// move reads up to three entries and evaluates up to four distances in the
// shared square-root unit; a reversal runs S_RVA, S_RVB, S_RVW per entry pair.
// Results then leave one by one from S_OUT; the receiver cannot stall them.
// Synchronous reset returns to idle, clears the margin and the load pointer,
// and sets segment count 1 and max passes 1000; store contents are kept.
module segment_path_two_opt_unit (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire spto_pkg::t_in_item  i_item,
    output logic                     o_strobe,
    output spto_pkg::t_out_item      o_result,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [1:0]          i_cfg_index,
    input  wire logic [15:0]         i_cfg_data
);
    import spto_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001, S_INIT = 14'b00000000000010,
        S_TRD  = 14'b00000000000100, S_TDIS = 14'b00000000001000,
        S_PASS = 14'b00000000010000, S_RDA  = 14'b00000000100000,
        S_RDB  = 14'b00000001000000, S_EVAL = 14'b00000010000000,
        S_DWT  = 14'b00000100000000, S_DEC  = 14'b00001000000000,
        S_RVA  = 14'b00010000000000, S_RVB  = 14'b00100000000000,
        S_RVW  = 14'b01000000000000, S_OUT  = 14'b10000000000000
    } t_state;

    t_state r_state;
    logic [6:0]  r_seg_count;
    logic [15:0] r_max_passes;
    logic [7:0]  r_margin;
    logic [CNT_BITS-1:0] r_load_ptr, r_n;
    logic [IDX_BITS-1:0] r_i, r_j, r_k, r_l, r_r;
    logic [CNT_BITS-1:0] r_kk;
    logic [15:0] r_passes;
    logic [ACC_BITS-1:0] r_tot, r_cur, r_new;
    logic [DIST_BITS-1:0] r_init_d;
    logic r_final;
    logic [1:0] r_rd, r_dn;
    t_entry r_ei, r_ej, r_ej1, r_ep, r_ta;
    t_coord r_px, r_py;

    logic                we;
    logic [IDX_BITS-1:0] waddr, raddr;
    t_entry              wdata, rdata;
    logic                dgo, ddone;
    t_coord              dx1, dy1, dx2, dy2;
    logic [ROOT_BITS-1:0] dval;
    logic [CNT_BITS-1:0] n_n;
    logic                has_j1;
    logic [DIST_BITS-1:0] sat_tot;

    spto_store u_store (.i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata));
    spto_dist u_dist (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(dgo), .i_x1(dx1),
        .i_y1(dy1), .i_x2(dx2), .i_y2(dy2), .o_done(ddone), .o_dist(dval));

    function automatic t_entry flip_e(t_entry e);
        t_entry f;
        f = e;
        f.sx = e.ex; f.sy = e.ey; f.ex = e.sx; f.ey = e.sy; f.flip = ~e.flip;
        return f;
    endfunction

    assign n_n = (r_seg_count == 7'd0) ? CNT_BITS'(1)
               : (r_seg_count > 7'(MAX_SEGMENTS)) ? CNT_BITS'(MAX_SEGMENTS)
               : CNT_BITS'(r_seg_count);
    assign has_j1 = (CNT_BITS'(r_j) + 1'b1) < r_n;
    assign busy = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign sat_tot = (r_tot > ACC_BITS'(DIST_MAX)) ? DIST_MAX : DIST_BITS'(r_tot);

    always_comb begin
        raddr = r_k;
        we = 1'b0; waddr = r_load_ptr[IDX_BITS-1:0]; wdata = r_ta;
        dgo = 1'b0; dx1 = r_px; dy1 = r_py; dx2 = r_ei.sx; dy2 = r_ei.sy;
        if (r_state == S_IDLE && start && !i_item.mode && r_load_ptr < CNT_BITS'(MAX_SEGMENTS)) begin
            we = 1'b1;
            wdata = '{sx: i_item.start_x, sy: i_item.start_y, ex: i_item.end_x,
                      ey: i_item.end_y, ord: r_load_ptr[IDX_BITS-1:0], flip: 1'b0};
        end
        if (r_state == S_RVA) raddr = r_r;
        if (r_state == S_RVB) begin
            we = 1'b1; waddr = r_l; wdata = flip_e(rdata);
        end
        if (r_state == S_RVW) begin
            we = 1'b1; waddr = r_r; wdata = flip_e(rdata);
        end
        if (r_state == S_TDIS && r_rd == 2'd0) begin
            dgo = 1'b1; dx2 = rdata.sx; dy2 = rdata.sy;
        end
        if (r_state == S_EVAL) begin
            dgo = 1'b1;
            case (r_dn)
                2'd0: begin dx2 = r_ei.sx; dy2 = r_ei.sy; end
                2'd1: begin dx2 = r_ej.ex; dy2 = r_ej.ey; end
                2'd2: begin dx1 = r_ej.ex; dy1 = r_ej.ey; dx2 = r_ej1.sx; dy2 = r_ej1.sy; end
                default: begin dx1 = r_ei.sx; dy1 = r_ei.sy; dx2 = r_ej1.sx; dy2 = r_ej1.sy; end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        o_strobe <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_seg_count <= 7'd1; r_max_passes <= 16'd1000;
            r_margin <= 8'd0; r_load_ptr <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        case (i_cfg_index)
                            REG_SEGMENT_COUNT: r_seg_count <= i_cfg_data[6:0];
                            REG_MAX_PASSES:    r_max_passes <= i_cfg_data;
                            REG_MARGIN:        r_margin <= i_cfg_data[7:0];
                            default: ;
                        endcase
                    end
                    if (start) begin
                        if (!i_item.mode) begin
                            if (r_load_ptr < CNT_BITS'(MAX_SEGMENTS))
                                r_load_ptr <= r_load_ptr + 1'b1;
                        end else begin
                            r_n <= n_n; r_passes <= '0; r_final <= 1'b0;
                            r_state <= S_INIT;
                        end
                    end
                end
                S_INIT: begin
                    r_tot <= '0; r_k <= '0; r_rd <= 2'd0;
                    r_px <= '0; r_py <= '0; r_state <= S_TRD;
                end
                S_TRD: r_state <= S_TDIS;
                S_TDIS: begin
                    if (r_rd == 2'd0) begin
                        r_ep <= rdata; r_rd <= 2'd1;
                    end else if (ddone) begin
                        r_tot <= r_tot + ACC_BITS'(dval);
                        r_px <= r_ep.ex; r_py <= r_ep.ey; r_rd <= 2'd0;
                        if (CNT_BITS'(r_k) + 1'b1 >= r_n) begin
                            if (!r_final) begin
                                r_init_d <= (r_tot + ACC_BITS'(dval) > ACC_BITS'(DIST_MAX))
                                    ? DIST_MAX : DIST_BITS'(r_tot + ACC_BITS'(dval));
                                r_state <= S_PASS;
                            end else begin
                                r_k <= '0; r_kk <= '0;
                                r_state <= S_OUT;
                            end
                        end else begin
                            r_k <= r_k + 1'b1; r_state <= S_TRD;
                        end
                    end
                end
                S_PASS: begin
                    if (r_n > CNT_BITS'(1) && r_passes < r_max_passes) begin
                        r_passes <= r_passes + 1'b1;
                        r_i <= '0; r_j <= IDX_BITS'(1); r_px <= '0; r_py <= '0;
                        r_k <= '0; r_rd <= 2'd0; r_state <= S_RDA;
                    end else begin
                        r_final <= 1'b1; r_state <= S_INIT;
                    end
                end
                S_RDA: begin
                    r_rd <= r_rd + 1'b1;
                    case (r_rd)
                        2'd0: r_k <= r_j;
                        2'd1: begin r_ei <= rdata; r_k <= r_j + 1'b1; end
                        2'd2: r_ej <= rdata;
                        default: ;
                    endcase
                    if (r_rd == 2'd3) begin
                        r_ej1 <= rdata; r_dn <= 2'd0; r_cur <= '0; r_new <= '0;
                        r_state <= S_EVAL;
                    end
                end
                S_RDB: r_state <= S_RDA;
                S_EVAL: r_state <= S_DWT;
                S_DWT: begin
                    if (ddone) begin
                        if (r_dn == 2'd0 || r_dn == 2'd2) r_cur <= r_cur + ACC_BITS'(dval);
                        else r_new <= r_new + ACC_BITS'(dval);
                        if (r_dn == 2'd3 || (r_dn == 2'd1 && !has_j1)) r_state <= S_DEC;
                        else begin r_dn <= r_dn + 1'b1; r_state <= S_EVAL; end
                    end
                end
                S_DEC: begin
                    if (r_new + ACC_BITS'(r_margin) < r_cur) begin
                        r_l <= r_i; r_r <= r_j; r_k <= r_i; r_state <= S_RVA;
                    end else if (has_j1) begin
                        r_j <= r_j + 1'b1; r_k <= r_i; r_rd <= 2'd0; r_state <= S_RDB;
                    end else if (CNT_BITS'(r_i) + 2'd2 < r_n) begin
                        r_px <= r_ei.ex; r_py <= r_ei.ey;
                        r_i <= r_i + 1'b1; r_j <= r_i + 2'd2;
                        r_k <= r_i + 1'b1; r_rd <= 2'd0; r_state <= S_RDB;
                    end else begin
                        r_final <= 1'b1; r_state <= S_INIT;
                    end
                end
                S_RVA: r_state <= S_RVB;
                S_RVB: begin
                    r_ta <= rdata; r_state <= S_RVW;
                end
                S_RVW: begin
                    if (r_l + 1'b1 >= r_r) begin
                        r_state <= S_PASS;
                    end else begin
                        r_l <= r_l + 1'b1; r_r <= r_r - 1'b1; r_k <= r_l + 1'b1;
                        r_state <= S_RVA;
                    end
                end
                S_OUT: begin
                    if (r_rd == 2'd0) begin
                        r_rd <= 2'd1; r_k <= r_k;
                    end else begin
                        o_strobe <= 1'b1;
                        o_result <= '{original_index: 6'(rdata.ord), flipped: rdata.flip,
                            last: (r_kk + 1'b1 == r_n), pass_count: r_passes,
                            initial_distance: r_init_d, final_distance: sat_tot};
                        r_kk <= r_kk + 1'b1;
                        r_k <= r_k + 1'b1;
                        r_rd <= 2'd0;
                        if (r_kk + 1'b1 == r_n) begin
                            r_load_ptr <= '0; r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_no_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_cfg_ready) else $error("config ready while busy");
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last |-> busy) else $error("result after run end");
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load_ptr <= CNT_BITS'(MAX_SEGMENTS)) else $error("load pointer overflow");
`endif
endmodule
`default_nettype wire
